>>> src/lphs_pkg.sv
// shared constants and types for the linear-probe hash set insert block
`default_nettype none
package lphs_pkg;

  localparam int TABLE_LOG2 = 12;
  localparam int ADDR_W     = TABLE_LOG2;
  localparam int PROBE_W    = TABLE_LOG2 + 1;
  localparam int KEY_W      = 64;
  localparam int CFG_W      = 4;
  localparam int COUNT_W    = 13;
  localparam int OUT_W      = 16;

  localparam logic [CFG_W-1:0]   SLOTS_LOG2_RESET = CFG_W'(12);
  localparam logic [CFG_W-1:0]   SLOTS_LOG2_MIN   = CFG_W'(1);
  localparam logic [CFG_W-1:0]   SLOTS_LOG2_MAX   = CFG_W'(TABLE_LOG2);
  localparam logic [COUNT_W-1:0] COUNT_MAX        = '1;
  localparam logic [KEY_W-1:0]   EMPTY_KEY        = '1;

  localparam logic [63:0] FMIX_C1    = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FMIX_C2    = 64'hc4ceb9fe1a85ec53;
  localparam int          FMIX_SHIFT = 33;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_PRESENT  = 2'd1,
    ST_FULL     = 2'd2,
    ST_REFUSED  = 2'd3
  } status_t;

endpackage
`default_nettype wire

>>> src/lphs_slot_ram.sv
// single-port-write, single-port-read synchronous ram with registered read data
`default_nettype none
module lphs_slot_ram #(
  parameter int ADDR_W = 12,
  parameter int DATA_W = 64
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> src/lphs_hash.sv
// murmur3 fmix64 finalizer on one shared 32x32 multiplier
`default_nettype none
module lphs_hash (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic [lphs_pkg::KEY_W-1:0]      key,
  output logic                                 done,
  output logic      [lphs_pkg::ADDR_W-1:0]     hash
);
  import lphs_pkg::*;

  logic        busy;
  logic [2:0]  ph;
  logic [1:0]  step;
  logic [63:0] v;
  logic [63:0] acc;
  logic [63:0] c;
  logic [63:0] mix;
  logic [31:0] a_op;
  logic [31:0] b_op;
  logic [63:0] prod;

  assign step = ph[1:0];
  assign c    = ph[2] ? FMIX_C2 : FMIX_C1;
  assign a_op = (step == 2'd2) ? v[63:32] : v[31:0];
  assign b_op = (step == 2'd1) ? c[63:32] : c[31:0];
  assign prod = a_op * b_op;
  assign mix  = acc ^ (acc >> FMIX_SHIFT);
  assign done = busy && (ph == 3'd7);
  assign hash = mix[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      ph   <= '0;
    end else if (start) begin
      busy <= 1'b1;
      ph   <= '0;
      v    <= key ^ (key >> FMIX_SHIFT);
    end else if (busy) begin
      ph <= ph + 3'd1;
      if (ph == 3'd7) begin
        busy <= 1'b0;
      end
      case (step)
        2'd0:    acc <= prod;
        2'd1,
        2'd2:    acc[63:32] <= acc[63:32] + prod[31:0];
        2'd3:    v <= mix;
        default: acc <= acc;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> src/linear_probe_hash_set_insert.sv
// linear-probe hash set insert: top level with probe sequencer and slot table
//
// Input stream s_axis carries one 64-bit key per beat. Each key gets one result
// beat on m_axis: status in bits 1:0 (inserted, present, full, refused) and the
// number of stored keys in bits 14:2.
// The cfg channel writes slots_log2 (slots in use = 2**slots_log2, clamped to
// 1..12); cfg_ready is always high, writes belong between items.
// Flow: a reserved all-ones key goes from accept straight to the output register.
// Any other key is accepted, hashed in the fmix64 unit (one 32x32 multiplier,
// four steps per 64-bit multiply and xor-shift), then waits for the first slot
// read, probes slot by slot and is loaded into the output register.
// One item is in work at a time; the next key is taken as soon as the previous
// result sits in the output register, even while that result is stalled.
// A full table probes every slot in use before it reports full.
// After reset the 4096-slot table is swept to empty, one slot a cycle, with
// s_axis_tready low; the count resets to zero.
// A stalled receiver holds the result; the block then waits before loading the
// next one.
`default_nettype none
module linear_probe_hash_set_insert (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [lphs_pkg::KEY_W-1:0]   s_axis_tdata,   // key[63:0]
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic      [lphs_pkg::OUT_W-1:0]   m_axis_tdata,   // status[1:0], stored_count[14:2]
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [lphs_pkg::CFG_W-1:0]   cfg_data
);
  import lphs_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_READ,
    S_PROBE,
    S_FINISH
  } state_t;

  state_t               state;
  logic [CFG_W-1:0]     slots_log2;
  logic [CFG_W-1:0]     used_log2;
  logic [PROBE_W-1:0]   limit;
  logic [ADDR_W-1:0]    mask;
  logic [ADDR_W-1:0]    clr_addr;
  logic [KEY_W-1:0]     key;
  logic [ADDR_W-1:0]    pos;
  logic [ADDR_W-1:0]    pos_next;
  logic [PROBE_W-1:0]   probes;
  logic [PROBE_W-1:0]   probes_next;
  logic [COUNT_W-1:0]   entry_count;
  status_t              status;
  logic                 accept;
  logic                 out_free;
  logic                 hash_start;
  logic                 hash_done;
  logic [ADDR_W-1:0]    hash;
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [KEY_W-1:0]     ram_wdata;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [KEY_W-1:0]     ram_rdata;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign hash_start    = accept && (s_axis_tdata != EMPTY_KEY);

  always_comb begin
    if (slots_log2 < SLOTS_LOG2_MIN) begin
      used_log2 = SLOTS_LOG2_MIN;
    end else if (slots_log2 > SLOTS_LOG2_MAX) begin
      used_log2 = SLOTS_LOG2_MAX;
    end else begin
      used_log2 = slots_log2;
    end
  end

  assign limit       = PROBE_W'(1) << used_log2;
  assign mask        = ADDR_W'(limit - PROBE_W'(1));
  assign pos_next    = (pos + ADDR_W'(1)) & mask;
  assign probes_next = probes + PROBE_W'(1);

  // probe reads run one slot ahead so that probes follow back to back
  assign ram_raddr = (state == S_PROBE) ? pos_next : pos;
  assign ram_we    = (state == S_CLEAR) || ((state == S_PROBE) && (ram_rdata == EMPTY_KEY));
  assign ram_waddr = (state == S_CLEAR) ? clr_addr : pos;
  assign ram_wdata = (state == S_CLEAR) ? EMPTY_KEY : key;

  lphs_hash u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hash_start),
    .key   (s_axis_tdata),
    .done  (hash_done),
    .hash  (hash)
  );

  lphs_slot_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (KEY_W)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      slots_log2    <= SLOTS_LOG2_RESET;
      clr_addr      <= '0;
      entry_count   <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        slots_log2 <= cfg_data;
      end
      if (m_axis_tvalid && m_axis_tready && (state != S_FINISH)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            key <= s_axis_tdata;
            if (s_axis_tdata == EMPTY_KEY) begin
              status <= ST_REFUSED;
              state  <= S_FINISH;
            end else begin
              state <= S_HASH;
            end
          end
        end
        S_HASH: begin
          if (hash_done) begin
            pos    <= hash & mask;
            probes <= '0;
            state  <= S_READ;
          end
        end
        S_READ: begin
          state <= S_PROBE;
        end
        S_PROBE: begin
          if (ram_rdata == EMPTY_KEY) begin
            if (entry_count != COUNT_MAX) begin
              entry_count <= entry_count + COUNT_W'(1);
            end
            status <= ST_INSERTED;
            state  <= S_FINISH;
          end else if (ram_rdata == key) begin
            status <= ST_PRESENT;
            state  <= S_FINISH;
          end else if (probes_next == limit) begin
            status <= ST_FULL;
            state  <= S_FINISH;
          end else begin
            pos    <= pos_next;
            probes <= probes_next;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {1'b0, entry_count, status};
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> sim/tb.sv
// testbench for the linear-probe hash set insert block: random keys, scoreboard check
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lphs_pkg::*;

  typedef struct packed {
    status_t              status;
    logic [COUNT_W-1:0]   count;
  } insert_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [KEY_W-1:0]   s_axis_tdata = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [OUT_W-1:0]   m_axis_tdata;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CFG_W-1:0]   cfg_data = '0;

  linear_probe_hash_set_insert dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic [KEY_W-1:0]   slot_mem [1 << TABLE_LOG2];
  logic [COUNT_W-1:0] held_count = '0;
  logic [CFG_W-1:0]   slots_cfg = SLOTS_LOG2_RESET;

  logic [KEY_W-1:0]   pending_keys[$];
  logic [KEY_W-1:0]   known_keys[$];
  insert_result_t     pending_results[$];
  int                 errors = 0;

  function automatic logic [63:0] murmur_mix64(input logic [63:0] v);
    v = v ^ (v >> FMIX_SHIFT);
    v = v * FMIX_C1;
    v = v ^ (v >> FMIX_SHIFT);
    v = v * FMIX_C2;
    v = v ^ (v >> FMIX_SHIFT);
    return v;
  endfunction

  function automatic insert_result_t predict_insert(input logic [KEY_W-1:0] k);
    insert_result_t r;
    int unsigned    lg;
    int unsigned    n;
    int unsigned    pos;
    int unsigned    probes;
    logic [63:0]    h;
    bit             settled;
    lg = slots_cfg;
    if (lg < SLOTS_LOG2_MIN) lg = SLOTS_LOG2_MIN;
    if (lg > SLOTS_LOG2_MAX) lg = SLOTS_LOG2_MAX;
    n = 1 << lg;
    r.status = ST_REFUSED;
    if (k != EMPTY_KEY) begin
      h = murmur_mix64(k);
      pos = h[ADDR_W-1:0] & (n - 1);
      r.status = ST_FULL;
      probes = 0;
      settled = 1'b0;
      while (!settled && probes < n) begin
        if (slot_mem[pos] == EMPTY_KEY) begin
          slot_mem[pos] = k;
          if (held_count != COUNT_MAX) held_count = held_count + 1'b1;
          r.status = ST_INSERTED;
          settled = 1'b1;
        end else if (slot_mem[pos] == k) begin
          r.status = ST_PRESENT;
          settled = 1'b1;
        end else begin
          pos = (pos + 1) & (n - 1);
          probes++;
        end
      end
    end
    r.count = held_count;
    return r;
  endfunction

  function automatic void note_error(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endfunction

  // sender: bursts of random length, random gaps between them
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_keys.size() != 0) begin
        s_axis_tdata  <= pending_keys.pop_front();
        s_axis_tvalid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: stall mode is redrawn each time its random hold count runs out
  int stall_mode = 0;
  int mode_left = 0;
  int rx_cycle = 0;
  always @(posedge clk) begin
    rx_cycle++;
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(64, 512);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0: begin
        m_axis_tready <= 1'b1;
      end
      1: begin
        m_axis_tready <= 1'($urandom_range(0, 1));
      end
      2: begin
        m_axis_tready <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        m_axis_tready <= rx_cycle[2];
      end
    endcase
  end

  // accepted config and key beats feed the predictor
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) slots_cfg = cfg_data;
      if (s_axis_tvalid && s_axis_tready)
        pending_results = {pending_results, predict_insert(s_axis_tdata)};
    end
  end

  // result beats against the oldest expectation
  always @(posedge clk) begin
    insert_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        note_error($sformatf("unexpected result beat %h", m_axis_tdata));
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[1:0] != want.status || m_axis_tdata[14:2] != want.count)
          note_error($sformatf("mismatch: status exp %0d got %0d, count exp %0d got %0d",
                               want.status, m_axis_tdata[1:0], want.count,
                               m_axis_tdata[14:2]));
      end
    end
  end

  task automatic wait_drained();
    while (pending_keys.size() != 0 || s_axis_tvalid || pending_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_slots_log2(input logic [CFG_W-1:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_key(input logic [KEY_W-1:0] k);
    pending_keys = {pending_keys, k};
    if (k != EMPTY_KEY) known_keys = {known_keys, k};
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55 || known_keys.size() == 0) return {$urandom, $urandom};
    if (r < 80) return known_keys[$urandom_range(0, known_keys.size() - 1)];
    if (r < 85) return EMPTY_KEY;
    if (r < 92) return KEY_W'($urandom_range(0, 255));
    if (r < 96) return ~(64'd1 << $urandom_range(0, 63));
    return 64'd1 << $urandom_range(0, 63);
  endfunction

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  int phase_cfg[12] = '{4, 12, 2, 8, 13, 6, 12, 3, 10, 14, 5, 12};

  initial begin
    foreach (slot_mem[i]) slot_mem[i] = EMPTY_KEY;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);

    // above the table size, clamps to full table
    write_slots_log2(4'd15);
    push_key(64'd0);
    push_key(64'd1);
    push_key(64'd2);
    push_key(64'h8000_0000_0000_0000);
    push_key(64'h7fff_ffff_ffff_ffff);
    push_key(64'hffff_ffff_ffff_fffe);
    push_key(EMPTY_KEY);
    push_key(64'd0);
    push_key(64'hffff_ffff_ffff_fffe);
    push_key(64'haaaa_aaaa_aaaa_aaaa);
    push_key(64'h5555_5555_5555_5555);

    // zero clamps to two slots: fills up, wraps, reports full
    write_slots_log2(4'd0);
    push_key(64'd3);
    push_key(64'd4);
    push_key(64'd5);
    push_key(64'd6);
    push_key(64'd0);
    push_key(EMPTY_KEY);

    write_slots_log2(4'd1);
    push_key(64'd7);
    push_key(64'd1);

    foreach (phase_cfg[p]) begin
      write_slots_log2(CFG_W'(phase_cfg[p]));
      repeat (111) push_key(pick_key());
    end

    wait_drained();
    repeat (64) @(posedge clk);
    if (pending_results.size() != 0)
      note_error($sformatf("%0d results never arrived", pending_results.size()));
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
